[src/stcc_pkg.sv]
// ----------------------------------------------------------------------------
// stcc_pkg
// Shared types and codes for the split table compatibility check.
// ----------------------------------------------------------------------------
package stcc_pkg;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_QUERY  = 2'd1;
    localparam logic [1:0] OP_INSERT = 2'd2;

    localparam logic [6:0] NUM_ELEMENTS_RESET = 7'd64;

    typedef struct packed {
        logic       valid;
        logic [1:0] op;
        logic       compat;
        logic       present;
    } t_ctl;

endpackage

[src/stcc_cell.sv]
// ----------------------------------------------------------------------------
// stcc_cell
// One table slot: holds a stored split, checks the passing request against it
// and hands the request on to the next slot through its output registers.
// ----------------------------------------------------------------------------
module stcc_cell #(
    parameter int IDX          = 0,
    parameter int MAX_SPLITS   = 32,
    parameter int MAX_ELEMENTS = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  stcc_pkg::t_ctl                     i_ctl,
    input  logic [MAX_ELEMENTS-1:0]            i_split,
    input  logic [MAX_ELEMENTS-1:0]            i_mask,
    input  logic [$clog2(MAX_SPLITS+1)-1:0]    i_count,
    output stcc_pkg::t_ctl                     o_ctl,
    output logic [MAX_ELEMENTS-1:0]            o_split
);

    localparam int CW = $clog2(MAX_SPLITS + 1);

    logic [MAX_ELEMENTS-1:0] r_store;
    logic [MAX_ELEMENTS-1:0] r_split;
    stcc_pkg::t_ctl          r_ctl;
    stcc_pkg::t_ctl          n_ctl;

    logic active;
    logic incompat;
    logic same;
    logic write_en;

    always_comb begin
        active   = (CW'(IDX) < i_count);
        incompat = (|(i_split & r_store & i_mask)) && (|(i_split & ~r_store & i_mask)) &&
                   (|(~i_split & r_store & i_mask)) && (|(~i_split & ~r_store & i_mask));
        same     = (((i_split ^ r_store) & i_mask) == '0) ||
                   (((i_split ^ ~r_store) & i_mask) == '0);
        write_en = i_ctl.valid && (i_ctl.op == stcc_pkg::OP_INSERT) && (i_count == CW'(IDX));
        n_ctl    = i_ctl;
        if (i_ctl.valid && (i_ctl.op != stcc_pkg::OP_CLEAR) && active) begin
            if (incompat) begin
                n_ctl.compat = 1'b0;
            end
            if (same) begin
                n_ctl.present = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_split <= i_split;
        if (write_en) begin
            r_store <= i_split;
        end
    end

    assign o_ctl   = r_ctl;
    assign o_split = r_split;

endmodule

[src/split_table_compatibility_check_top.sv]
// ----------------------------------------------------------------------------
// split_table_compatibility_check_top
// Table of bipartitions with a four-gamete compatibility and presence check.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+------------------------------
//   request | in        | i_in_valid / o_in_stall   | opcode, split_bits
//   result  | out       | o_out_valid / i_out_stall | all_compatible, already_present,
//           |           |                           | table_full_drop, entry_count
//   config  | in        | i_cfg_we                  | i_cfg_wdata (num_elements)
//
// A request walks the chain of MAX_SPLITS cells, one cell per cycle, and
// o_in_stall stays high from acceptance until its result enters the output register.
// The result lands in the output register, which holds while i_out_stall is high;
// a new request is taken while that result still waits.
// Synchronous active-low reset empties the table and sets num_elements to 64.
// ----------------------------------------------------------------------------
module split_table_compatibility_check_top #(
    parameter int MAX_SPLITS   = 32,
    parameter int MAX_ELEMENTS = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [1:0]                        i_opcode,
    input  logic [MAX_ELEMENTS-1:0]           i_split_bits,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_all_compatible,
    output logic                              o_already_present,
    output logic                              o_table_full_drop,
    output logic [$clog2(MAX_SPLITS+1)-1:0]   o_entry_count,
    input  logic                              i_cfg_we,
    input  logic [6:0]                        i_cfg_wdata
);

    localparam int CW = $clog2(MAX_SPLITS + 1);

    logic [6:0]              r_num_elements;
    logic [MAX_ELEMENTS-1:0] mask;
    logic                    accept;

    logic                    r_busy;
    logic                    n_busy;
    logic [CW-1:0]           r_count;
    logic [CW-1:0]           n_count;

    stcc_pkg::t_ctl          r_head_ctl;
    logic [MAX_ELEMENTS-1:0] r_head_split;

    stcc_pkg::t_ctl          chain_ctl   [0:MAX_SPLITS];
    logic [MAX_ELEMENTS-1:0] chain_split [0:MAX_SPLITS];

    stcc_pkg::t_ctl          exit_ctl;
    logic                    exit_drop;

    logic                    r_res_valid;
    logic                    r_res_compat;
    logic                    r_res_present;
    logic                    r_res_drop;
    logic [CW-1:0]           r_res_count;
    logic                    move_out;

    logic                    r_out_valid;
    logic                    r_out_compat;
    logic                    r_out_present;
    logic                    r_out_drop;
    logic [CW-1:0]           r_out_count;

    always_comb begin
        for (int b = 0; b < MAX_ELEMENTS; b++) begin
            mask[b] = (r_num_elements > 7'(b));
        end
    end

    assign accept   = i_in_valid && !r_busy;
    assign exit_ctl = chain_ctl[MAX_SPLITS];
    assign move_out = r_res_valid && (!r_out_valid || !i_out_stall);

    always_comb begin
        exit_drop = (exit_ctl.op == stcc_pkg::OP_INSERT) && (r_count == CW'(MAX_SPLITS));
        n_count   = r_count;
        if (exit_ctl.valid) begin
            if (exit_ctl.op == stcc_pkg::OP_CLEAR) begin
                n_count = '0;
            end else if (exit_ctl.op == stcc_pkg::OP_INSERT && !exit_drop) begin
                n_count = r_count + 1'b1;
            end
        end
        n_busy = r_busy;
        if (accept) begin
            n_busy = 1'b1;
        end else if (move_out) begin
            n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_elements <= stcc_pkg::NUM_ELEMENTS_RESET;
            r_busy         <= 1'b0;
            r_count        <= '0;
            r_head_ctl     <= '0;
            r_res_valid    <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_num_elements <= i_cfg_wdata;
            end
            r_busy               <= n_busy;
            r_count              <= n_count;
            r_head_ctl.valid     <= accept;
            r_head_ctl.op        <= i_opcode;
            r_head_ctl.compat    <= 1'b1;
            r_head_ctl.present   <= 1'b0;
            if (exit_ctl.valid) begin
                r_res_valid <= 1'b1;
            end else if (move_out) begin
                r_res_valid <= 1'b0;
            end
            if (move_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_head_split <= i_split_bits & mask;
        if (exit_ctl.valid) begin
            r_res_compat  <= exit_ctl.compat;
            r_res_present <= exit_ctl.present;
            r_res_drop    <= exit_drop;
            r_res_count   <= n_count;
        end
        if (move_out) begin
            r_out_compat  <= r_res_compat;
            r_out_present <= r_res_present;
            r_out_drop    <= r_res_drop;
            r_out_count   <= r_res_count;
        end
    end

    assign chain_ctl[0]   = r_head_ctl;
    assign chain_split[0] = r_head_split;

    for (genvar g = 0; g < MAX_SPLITS; g++) begin : g_cell
        stcc_cell #(
            .IDX          (g),
            .MAX_SPLITS   (MAX_SPLITS),
            .MAX_ELEMENTS (MAX_ELEMENTS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (chain_ctl[g]),
            .i_split (chain_split[g]),
            .i_mask  (mask),
            .i_count (r_count),
            .o_ctl   (chain_ctl[g+1]),
            .o_split (chain_split[g+1])
        );
    end

    assign o_in_stall        = r_busy;
    assign o_out_valid       = r_out_valid;
    assign o_all_compatible  = r_out_compat;
    assign o_already_present = r_out_present;
    assign o_table_full_drop = r_out_drop;
    assign o_entry_count     = r_out_count;

endmodule

[src/stcc_checker.sv]
// ----------------------------------------------------------------------------
// stcc_checker
// Port-level checks for the split table compatibility check.
// ----------------------------------------------------------------------------
module stcc_checker #(
    parameter int MAX_SPLITS   = 32
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_stall,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic                              o_all_compatible,
    input logic                              o_already_present,
    input logic                              o_table_full_drop,
    input logic [$clog2(MAX_SPLITS+1)-1:0]   o_entry_count
);

    localparam int CW = $clog2(MAX_SPLITS + 1);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_entry_count) &&
        $stable(o_all_compatible) && $stable(o_already_present) &&
        $stable(o_table_full_drop))
        else $error("result changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request taken without going busy");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_entry_count <= CW'(MAX_SPLITS))
        else $error("entry count beyond table size");

    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_table_full_drop |-> o_entry_count == CW'(MAX_SPLITS))
        else $error("drop reported with room in table");

    a_present_compat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_already_present |-> o_all_compatible || o_entry_count > 1)
        else $error("present split reported incompatible with a lone entry");

endmodule

bind split_table_compatibility_check_top stcc_checker #(
    .MAX_SPLITS   (MAX_SPLITS)
) u_stcc_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in_valid),
    .o_in_stall        (o_in_stall),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_all_compatible  (o_all_compatible),
    .o_already_present (o_already_present),
    .o_table_full_drop (o_table_full_drop),
    .o_entry_count     (o_entry_count)
);
